### sv/tsum_pkg.sv
// Shared types, constants and a ones-complement fold helper for the transport checksum block.
package tsum_pkg;

   localparam logic [7:0] PROTO_UDP = 8'd17;
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [15:0] UDP_LEN_POS = 16'd5;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic        first;
      logic        last;
      logic        unsupported;
      logic [15:0] hdr_sum;
      logic [15:0] data_sum;
   } tsum_entry_type;

   function automatic logic [15:0] oc_fold(input logic [18:0] raw);
      logic [16:0] partial;
      logic [16:0] result;
      partial = {1'b0, raw[15:0]} + {14'd0, raw[18:16]};
      result  = {1'b0, partial[15:0]} + {16'd0, partial[16]};
      return result[15:0];
   endfunction

endpackage

### sv/tsum_front.sv
// Front end: accepts segment bytes, tracks segment position and builds queue entries.
module tsum_front import tsum_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic [7:0]     req_data_byte,
   input  logic           req_last_byte,
   input  logic [31:0]    req_source_address,
   input  logic [31:0]    req_dest_address,
   input  logic [7:0]     req_proto_number,
   input  logic           queue_full,
   output logic           push,
   output tsum_entry_type entry
);

   logic        in_segment_ff, in_segment_in;
   logic [15:0] byte_count_ff, byte_count_in;
   logic [7:0]  high_byte_ff, high_byte_in;
   logic [7:0]  protocol_ff, protocol_in;

   logic        first;
   logic [15:0] pos;
   logic [15:0] count_next;
   logic [7:0]  proto_eff;
   logic        is_udp;
   logic        is_tcp;
   logic [15:0] word;
   logic [15:0] data_word;
   logic [15:0] tcp_len;
   logic [18:0] hdr_raw;

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      first      = !in_segment_ff;
      pos        = first ? 16'd0 : byte_count_ff;
      count_next = pos + 16'd1;
      proto_eff  = first ? req_proto_number : protocol_ff;
      is_udp     = (proto_eff == PROTO_UDP);
      is_tcp     = (proto_eff == PROTO_TCP);
      word       = {high_byte_ff, req_data_byte};

      if (pos[0]) begin
         if (pos == UDP_LEN_POS && is_udp) begin
            data_word = {word[14:0], word[15]};
         end else begin
            data_word = word;
         end
      end else if (req_last_byte) begin
         data_word = {req_data_byte, 8'd0};
      end else begin
         data_word = 16'd0;
      end

      tcp_len = (req_last_byte && is_tcp) ? count_next : 16'd0;

      hdr_raw = {3'd0, req_source_address[31:16]} + {3'd0, req_source_address[15:0]}
              + {3'd0, req_dest_address[31:16]} + {3'd0, req_dest_address[15:0]}
              + {11'd0, req_proto_number};

      entry.first       = first;
      entry.last        = req_last_byte;
      entry.unsupported = !(is_udp || is_tcp);
      entry.hdr_sum     = first ? oc_fold(hdr_raw) : 16'd0;
      entry.data_sum    = oc_fold({3'd0, data_word} + {3'd0, tcp_len});

      in_segment_in = in_segment_ff;
      byte_count_in = byte_count_ff;
      high_byte_in  = high_byte_ff;
      protocol_in   = protocol_ff;
      if (push) begin
         protocol_in = proto_eff;
         if (req_last_byte) begin
            in_segment_in = 1'b0;
            byte_count_in = 16'd0;
            high_byte_in  = 8'd0;
         end else begin
            in_segment_in = 1'b1;
            byte_count_in = count_next;
            if (!pos[0]) begin
               high_byte_in = req_data_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_segment_ff <= 1'b0;
         byte_count_ff <= 16'd0;
         high_byte_ff  <= 8'd0;
         protocol_ff   <= 8'd0;
      end else begin
         in_segment_ff <= in_segment_in;
         byte_count_ff <= byte_count_in;
         high_byte_ff  <= high_byte_in;
         protocol_ff   <= protocol_in;
      end
   end

endmodule

### sv/tsum_queue.sv
// Short queue of classified items between the front end and the accumulator.
module tsum_queue import tsum_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  tsum_entry_type push_entry,
   output logic           full,
   input  logic           pop,
   output logic           head_valid,
   output tsum_entry_type head_entry
);

   tsum_entry_type            slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]    count_ff, count_in;
   logic                      do_pop;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slots_ff[rd_ptr_ff];

   always_comb begin
      do_pop    = pop && head_valid;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### sv/tsum_back.sv
// Back end: ones-complement accumulation and the registered result stage.
module tsum_back import tsum_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           head_valid,
   input  tsum_entry_type head_entry,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic [15:0]    rsp_checksum_value,
   output logic           rsp_unsupported
);

   logic [15:0] acc_ff, acc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] checksum_ff;
   logic        unsupported_ff;
   logic [15:0] base;
   logic [15:0] total;
   logic        emit;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_checksum_value = checksum_ff;
   assign rsp_unsupported    = unsupported_ff;

   always_comb begin
      pop   = head_valid && (!head_entry.last || !rsp_valid_ff || rsp_ready);
      emit  = pop && head_entry.last;
      base  = head_entry.first ? 16'd0 : acc_ff;
      total = oc_fold({3'd0, base} + {3'd0, head_entry.hdr_sum}
                      + {3'd0, head_entry.data_sum});
      acc_in = pop ? total : acc_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         checksum_ff    <= head_entry.unsupported ? 16'd0 : ~total;
         unsupported_ff <= head_entry.unsupported;
      end
   end

endmodule

### sv/transport_pseudo_header_checksum_top.sv
// Top level of the TCP/UDP pseudo-header checksum block.
// The block takes one segment byte per cycle and keeps that rate across segment boundaries as
// long as checksum items are taken at the output. Addresses and protocol are sampled with the
// first byte of each segment. With the queue empty and the output register free, the entry
// of the last byte is queued and rsp_valid is registered when it is popped. The rate is set by
// the accumulator, which performs one ones-complement add and fold per cycle, and a four-entry
// queue between the classifying front end and the accumulator absorbs output stalls; once it
// is full behind a waiting checksum item, the input is held off. Protocols other than UDP and
// TCP give a zero checksum with the unsupported flag set.
module transport_pseudo_header_checksum_top import tsum_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [31:0] req_source_address,
   input  logic [31:0] req_dest_address,
   input  logic [7:0]  req_proto_number,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_checksum_value,
   output logic        rsp_unsupported
);

   tsum_entry_type push_entry;
   tsum_entry_type head_entry;
   logic           push;
   logic           full;
   logic           pop;
   logic           head_valid;

   tsum_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .req_source_address (req_source_address),
      .req_dest_address   (req_dest_address),
      .req_proto_number   (req_proto_number),
      .queue_full         (full),
      .push               (push),
      .entry              (push_entry)
   );

   tsum_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   tsum_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_entry         (head_entry),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_checksum_value (rsp_checksum_value),
      .rsp_unsupported    (rsp_unsupported)
   );

endmodule

### bench/tsum_checker.sv
// Checker that predicts each checksum item from the accepted bytes and compares the results.
`timescale 1ns / 1ps

module tsum_checker import tsum_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [31:0] req_source_address,
   input  logic [31:0] req_dest_address,
   input  logic [7:0]  req_proto_number,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_checksum_value,
   input  logic        rsp_unsupported,
   output int          mismatch_count,
   output int          awaiting_count
);

   typedef struct {
      logic [15:0] checksum;
      logic        unsupported;
   } checksum_item_type;

   checksum_item_type expected_checksums[$];
   int                mismatches = 0;

   logic [15:0] seg_sum;
   logic [15:0] seg_bytes;
   logic [7:0]  seg_high_byte;
   logic        seg_open;
   logic [7:0]  seg_protocol;

   function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] word);
      logic [16:0] total;
      total = {1'b0, acc} + {1'b0, word};
      return total[15:0] + {15'd0, total[16]};
   endfunction

   task automatic clear_segment();
      seg_open      = 1'b0;
      seg_sum       = 16'd0;
      seg_bytes     = 16'd0;
      seg_high_byte = 8'd0;
   endtask

   task automatic absorb_byte();
      logic [15:0]       position;
      logic [15:0]       word;
      logic [15:0]       total;
      checksum_item_type item;
      if (!seg_open) begin
         seg_open      = 1'b1;
         seg_bytes     = 16'd0;
         seg_high_byte = 8'd0;
         seg_protocol  = req_proto_number;
         seg_sum       = ones_add(16'd0, req_source_address[31:16]);
         seg_sum       = ones_add(seg_sum, req_source_address[15:0]);
         seg_sum       = ones_add(seg_sum, req_dest_address[31:16]);
         seg_sum       = ones_add(seg_sum, req_dest_address[15:0]);
         seg_sum       = ones_add(seg_sum, {8'd0, req_proto_number});
      end
      position = seg_bytes;
      if (!position[0]) begin
         seg_high_byte = req_data_byte;
      end else begin
         word    = {seg_high_byte, req_data_byte};
         seg_sum = ones_add(seg_sum, word);
         if (position == UDP_LEN_POS && seg_protocol == PROTO_UDP) begin
            seg_sum = ones_add(seg_sum, word);
         end
      end
      seg_bytes = position + 16'd1;
      if (req_last_byte) begin
         total = seg_sum;
         if (seg_bytes[0]) begin
            total = ones_add(total, {seg_high_byte, 8'd0});
         end
         if (seg_protocol == PROTO_TCP) begin
            total = ones_add(total, seg_bytes);
         end
         if (seg_protocol == PROTO_UDP || seg_protocol == PROTO_TCP) begin
            item.checksum    = ~total;
            item.unsupported = 1'b0;
         end else begin
            item.checksum    = 16'd0;
            item.unsupported = 1'b1;
         end
         expected_checksums.push_back(item);
         clear_segment();
      end
   endtask

   always @(posedge clock) begin
      checksum_item_type item;
      if (reset) begin
         expected_checksums.delete();
         clear_segment();
         seg_protocol = 8'd0;
      end else begin
         if (req_valid && req_ready) begin
            absorb_byte();
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_checksums.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: checksum item with none expected: %h unsupported %b",
                           $time, rsp_checksum_value, rsp_unsupported);
               end
            end else begin
               item = expected_checksums.pop_front();
               if (rsp_checksum_value !== item.checksum ||
                   rsp_unsupported !== item.unsupported) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: checksum expected %h unsupported %b, got %h unsupported %b",
                              $time, item.checksum, item.unsupported,
                              rsp_checksum_value, rsp_unsupported);
                  end
               end
            end
         end
      end
      mismatch_count <= mismatches;
      awaiting_count <= expected_checksums.size();
   end

endmodule

### bench/tb_top.sv
// Testbench top that drives segment bytes into the checksum block and gives the verdict.
`timescale 1ns / 1ps

module tb_top import tsum_pkg::*; ;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 1600;

   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte      = 8'd0;
   logic        req_last_byte      = 1'b0;
   logic [31:0] req_source_address = 32'd0;
   logic [31:0] req_dest_address   = 32'd0;
   logic [7:0]  req_proto_number   = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready          = 1'b0;
   logic [15:0] rsp_checksum_value;
   logic        rsp_unsupported;

   int   mismatch_count;
   int   awaiting_count;
   int   items_sent     = 0;
   int   quiet_cycles   = 0;
   logic idling_on      = 1'b1;
   int   stall_requests = 0;

   transport_pseudo_header_checksum_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .req_source_address (req_source_address),
      .req_dest_address   (req_dest_address),
      .req_proto_number   (req_proto_number),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_checksum_value (rsp_checksum_value),
      .rsp_unsupported    (rsp_unsupported)
   );

   tsum_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .req_source_address (req_source_address),
      .req_dest_address   (req_dest_address),
      .req_proto_number   (req_proto_number),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_checksum_value (rsp_checksum_value),
      .rsp_unsupported    (rsp_unsupported),
      .mismatch_count     (mismatch_count),
      .awaiting_count     (awaiting_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic offer_byte(input logic [7:0] data, input logic last, input logic [31:0] src,
                             input logic [31:0] dst, input logic [7:0] proto);
      if (idling_on && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data_byte      <= data;
      req_last_byte      <= last;
      req_source_address <= src;
      req_dest_address   <= dst;
      req_proto_number   <= proto;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_segment(input logic [31:0] src, input logic [31:0] dst,
                               input logic [7:0] proto, input int length,
                               input logic [15:0] udp_length);
      logic [7:0] data;
      logic       last;
      for (int i = 0; i < length; i++) begin
         data = 8'($urandom);
         last = (i == length - 1);
         if (proto == PROTO_UDP && i == 4) data = udp_length[15:8];
         if (proto == PROTO_UDP && i == 5) data = udp_length[7:0];
         if (i == 0) begin
            offer_byte(data, last, src, dst, proto);
         end else begin
            offer_byte(data, last, $urandom, $urandom, 8'($urandom));
         end
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaiting_count != 0) @(posedge clock);
   endtask

   initial begin
      int          length;
      int          pick;
      logic [7:0]  proto;
      logic [15:0] udp_length;
      bit          stalled_early;
      bit          stalled_late;
      bit          drained;
      stalled_early = 1'b0;
      stalled_late  = 1'b0;
      drained       = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part: extremes, odd and short segments, other protocols, a zero checksum.
      offer_byte(8'hFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PROTO_UDP);
      offer_byte(8'h00, 1'b1, 32'h0000_0000, 32'h0000_0000, PROTO_TCP);
      offer_byte(8'hA5, 1'b1, 32'h1234_5678, 32'h9ABC_DEF0, 8'd0);
      offer_byte(8'h00, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 8'd255);
      offer_byte(8'hFF, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF, PROTO_TCP);
      send_segment(32'hC0A8_0001, 32'h0A00_0002, PROTO_TCP, 3, 16'd0);
      send_segment(32'h7F00_0001, 32'h7F00_0001, PROTO_UDP, 5, 16'd5);
      offer_byte(8'hFF, 1'b0, 32'h0000_0000, 32'h0000_0000, PROTO_TCP);
      offer_byte(8'hF7, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
      send_segment($urandom, $urandom, PROTO_UDP, 8, 16'd8);

      while (items_sent < RANDOM_ITEMS) begin
         if (!stalled_early && items_sent >= 400) begin
            stalled_early = 1'b1;
            stall_requests <= stall_requests + 1;
         end
         if (!drained && items_sent >= 650) begin
            drained = 1'b1;
            drain_results();
            idling_on <= 1'b0;
         end
         if (items_sent >= 1000) idling_on <= 1'b1;
         if (!stalled_late && items_sent >= 1200) begin
            stalled_late  = 1'b1;
            stall_requests <= stall_requests + 1;
         end
         pick = $urandom_range(0, 9);
         if (pick < 4) proto = PROTO_UDP;
         else if (pick < 8) proto = PROTO_TCP;
         else proto = 8'($urandom);
         length = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
         udp_length = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'(length);
         send_segment($urandom, $urandom, proto, length, udp_length);
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && awaiting_count == 0) begin
         $display("transport_pseudo_header_checksum_top verification clean");
      end else begin
         $display("transport_pseudo_header_checksum_top verification failed");
      end
      $finish;
   end

   initial begin
      int stalls_served;
      stalls_served = 0;
      forever begin
         @(posedge clock);
         if (stall_requests != stalls_served) begin
            stalls_served++;
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
         end else if (idling_on && $urandom_range(0, 99) < 17) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("transport_pseudo_header_checksum_top verification failed");
      $finish;
   end

endmodule
